// File: rtl/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue
// no dependencies; used by every file in rtl
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int OUT_CNT_W = 5;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t command;
    key_t key;
  } req_t;

  typedef struct packed {
    logic                 ok;
    key_t                 value;
    logic [OUT_CNT_W-1:0] count;
    key_t                 top;
  } rsp_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
    key_t key;
  } cell_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
// spq_cell: one slot of the descending key chain
// depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               valid,
  input  logic               left_ge,
  input  spq_pkg::key_t      left_key,
  input  spq_pkg::key_t      right_key,
  output logic               ge,
  output spq_pkg::key_t      key
);

  spq_pkg::key_t key_next;

  // new key belongs at or above this slot
  assign ge = !valid || (ctrl.key >= key);

  always_comb begin
    key_next = key;
    if (ctrl.enq) begin
      if (ge) begin
        key_next = left_ge ? left_key : ctrl.key;
      end
    end else if (ctrl.deq) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

// File: rtl/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue as a chain of compare/shift cells
// the result strobe and result are registered at the accepting edge; one beat per cycle,
// busy is never raised, since every cell compares and shifts in the same cycle
// reset: synchronous rst empties the queue and clears the result strobe
// depends on spq_pkg and spq_cell
module sorted_priority_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t request,
  output logic          done,
  output spq_pkg::rsp_t result
);

  spq_pkg::cnt_t       count, count_next;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::rsp_t       result_next;
  spq_pkg::key_t       keys [spq_pkg::CAPACITY];
  logic                ges  [spq_pkg::CAPACITY];
  logic                valids [spq_pkg::CAPACITY];
  logic                accept, full, empty;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign empty  = (count == '0);

  assign ctrl.enq = accept && (request.command == spq_pkg::CMD_ENQ) && !full;
  assign ctrl.deq = accept && (request.command == spq_pkg::CMD_DEQ) && !empty;
  assign ctrl.key = request.key;

  for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
    assign valids[i] = count > spq_pkg::CNT_W'(i);
    spq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .valid    (valids[i]),
      .left_ge  ((i == 0) ? 1'b0 : ges[(i == 0) ? 0 : i-1]),
      .left_key (keys[(i == 0) ? 0 : i-1]),
      .right_key(keys[(i == spq_pkg::CAPACITY-1) ? i : i+1]),
      .ge       (ges[i]),
      .key      (keys[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + 1'b1;
    end else if (ctrl.deq) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    result_next.ok    = ctrl.enq || ctrl.deq;
    result_next.value = ctrl.deq ? keys[0] : '0;
    result_next.count = spq_pkg::OUT_CNT_W'(count_next);
    if (ctrl.enq) begin
      result_next.top = ges[0] ? request.key : keys[0];
    end else if (ctrl.deq) begin
      result_next.top = (count > spq_pkg::CNT_W'(1)) ? keys[1] : '0;
    end else begin
      result_next.top = empty ? '0 : keys[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// File: rtl/spq_checker.sv
// spq_checker: port-level checks for sorted_priority_queue, bound to the top level
// depends on spq_pkg
module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input spq_pkg::req_t request,
  input logic          done,
  input spq_pkg::rsp_t result
);

  // every accepted beat gives exactly one result beat next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("missing result beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result beat without request");

  a_fail_value: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.value == '0))
    else $error("failed beat carries a value");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (done && result.count == '0) |-> (result.top == '0))
    else $error("empty queue reports a top key");

  a_deq_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == spq_pkg::CMD_DEQ)
      |=> (result.ok || result.count == '0))
    else $error("dequeue refused on non-empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .request(request),
  .done   (done),
  .result (result)
);

// File: test/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue, mirroring
// the ordered key store in the bench and checking every result strobe
// depends on spq_pkg and sorted_priority_queue
module tb_sorted_priority_queue;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  logic           clk = 1'b0;
  logic           rst;
  logic           start;
  logic           busy;
  spq_pkg::req_t  request;
  logic           done;
  spq_pkg::rsp_t  result;

  spq_pkg::key_t  shadow_keys [spq_pkg::CAPACITY];
  int             shadow_count = 0;
  spq_pkg::rsp_t  queue_replies [$];
  spq_pkg::rsp_t  oldest_reply;
  int             gap_pct = 0;
  int             beats_sent = 0;
  int             results_seen = 0;
  int             fail_count = 0;
  int             full_refusals = 0;
  int             empty_refusals = 0;
  int             cycles = 0;

  sorted_priority_queue dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic spq_pkg::rsp_t apply_queue_op(spq_pkg::req_t op);
    spq_pkg::rsp_t r;
    int            pos;
    r = '0;
    if (op.command == spq_pkg::CMD_ENQ) begin
      if (shadow_count < spq_pkg::CAPACITY) begin
        pos = 0;
        while (pos < shadow_count && !(op.key < shadow_keys[pos])) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[pos] = op.key;
        shadow_count++;
        r.ok = 1'b1;
      end else begin
        full_refusals++;
      end
    end else begin
      if (shadow_count > 0) begin
        shadow_count--;
        r.value = shadow_keys[shadow_count];
        r.ok = 1'b1;
      end else begin
        empty_refusals++;
      end
    end
    r.count = spq_pkg::OUT_CNT_W'(shadow_count);
    r.top = (shadow_count > 0) ? shadow_keys[shadow_count-1] : spq_pkg::key_t'(0);
    return r;
  endfunction

  task automatic check_field(string name, logic [spq_pkg::KEY_W-1:0] want,
                             logic [spq_pkg::KEY_W-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (queue_replies.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, result);
          fail_count++;
        end else begin
          oldest_reply = queue_replies.pop_front();
          check_field("ok", oldest_reply.ok, result.ok);
          check_field("value", oldest_reply.value, result.value);
          check_field("count", oldest_reply.count, result.count);
          check_field("top", oldest_reply.top, result.top);
          results_seen++;
        end
      end
      if (start && !busy) queue_replies.push_back(apply_queue_op(request));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_beat(spq_pkg::cmd_t cmd, spq_pkg::key_t key);
    start <= 1'b1;
    request <= '{command: cmd, key: key};
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  function automatic spq_pkg::key_t pick_key();
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: return spq_pkg::key_t'($urandom);
      5, 6, 7:       return spq_pkg::key_t'(int'($urandom_range(8, 0)) - 4);
      8: begin
        case ($urandom_range(3, 0))
          0: return 32'sh80000000;
          1: return 32'sh7fffffff;
          2: return 32'sh00000000;
          default: return 32'shffffffff;
        endcase
      end
      default: begin
        if (shadow_count > 0) return shadow_keys[$urandom_range(shadow_count - 1, 0)];
        return spq_pkg::key_t'($urandom);
      end
    endcase
  endfunction

  task automatic test_empty_dequeue();
    send_beat(spq_pkg::CMD_DEQ, 32'sh12345678);
  endtask

  task automatic test_fill_with_extremes();
    spq_pkg::key_t fill_keys [16];
    fill_keys = '{32'sh80000000, 32'sh7fffffff, 32'sh00000000, 32'shffffffff,
                  32'sh00000001, 32'sh7fffffff, 32'sh80000000, 32'sh40000000,
                  32'shc0000000, 32'sh00000007, 32'sh00000007, 32'sh55555555,
                  32'shaaaaaaaa, 32'sh7ffffffe, 32'sh80000001, 32'sh00000003};
    foreach (fill_keys[i]) send_beat(spq_pkg::CMD_ENQ, fill_keys[i]);
  endtask

  task automatic test_full_refusal();
    send_beat(spq_pkg::CMD_ENQ, 32'sh7fffffff);
    send_beat(spq_pkg::CMD_ENQ, 32'sh80000000);
  endtask

  task automatic test_dequeue_order();
    repeat (4) send_beat(spq_pkg::CMD_DEQ, spq_pkg::key_t'($urandom));
  endtask

  task automatic test_random_ops(int n, int idle_pct);
    int enq_pct;
    int burst;
    gap_pct = idle_pct;
    enq_pct = 50;
    burst = 0;
    repeat (n) begin
      if (burst == 0) begin
        case ($urandom_range(2, 0))
          0: enq_pct = 20;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
        burst = $urandom_range(60, 10);
      end
      burst--;
      send_beat(($urandom_range(99, 0) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ,
                pick_key());
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_dequeue();
    test_fill_with_extremes();
    test_full_refusal();
    test_dequeue_order();
    test_random_ops(550, 0);
    test_random_ops(550, 49);
    test_random_ops(550, 17);

    start <= 1'b0;
    while (queue_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d beats with %0d full refusals and %0d empty dequeues",
             beats_sent, full_refusals, empty_refusals);
    $display("checked %0d results, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
test/tb_sorted_priority_queue.sv
